>>> rtl/dhh_pkg.sv
package dhh_pkg;

  localparam int STRIP_BINS_DEF     = 1024;
  localparam int AMPLITUDE_BINS_DEF = 1024;
  localparam int COUNT_WIDTH_DEF    = 32;
  localparam int SHIFT_WIDTH        = 6;

  localparam logic [1:0] OP_HIT     = 2'd0;
  localparam logic [1:0] OP_CLUSTER = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;
  localparam logic [1:0] OP_READ    = 2'd3;

  localparam logic [2:0] SEL_X_STRIP           = 3'd0;
  localparam logic [2:0] SEL_Y_STRIP           = 3'd1;
  localparam logic [2:0] SEL_X_AMPLITUDE       = 3'd2;
  localparam logic [2:0] SEL_Y_AMPLITUDE       = 3'd3;
  localparam logic [2:0] SEL_CLUSTER_AMPLITUDE = 3'd4;

  typedef struct packed {
    logic [1:0]  op;
    logic [9:0]  x_strip;
    logic [9:0]  x_amplitude;
    logic [9:0]  y_strip;
    logic [9:0]  y_amplitude;
    logic [31:0] cluster_sum;
    logic [2:0]  read_histogram;
    logic [9:0]  read_bin;
  } item_t;

  typedef struct packed {
    logic [31:0] bin_count;
    logic [31:0] hit_total;
    logic [31:0] cluster_total;
    logic        is_empty;
    logic        range_error;
  } result_t;

endpackage

>>> rtl/dhh_in_if.sv
interface dhh_in_if;
  logic           valid;
  logic           ready;
  dhh_pkg::item_t word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

>>> rtl/dhh_out_if.sv
interface dhh_out_if;
  logic             valid;
  logic             ready;
  dhh_pkg::result_t word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

>>> rtl/detector_hit_histogram_engine.sv
// Detector hit histogram engine. Five bin-count histograms (x strip, y strip, x amplitude,
// y amplitude, cluster amplitude) live in synchronous memories with registered reads and are
// updated by read, increment and write-back; a hit and a cluster total sit in flip-flops.
// Each accepted word passes the idle state, which takes it and issues the memory reads, then the
// execute state, which adds, writes back and loads the result register and waits while the
// result side is stalled; a new word is taken only back in idle. After reset, and after each
// clear word, all memories are swept to zero one entry per cycle over addresses 0 to
// max(STRIP_BINS, AMPLITUDE_BINS)-1, during which no word is accepted (the result of the clear
// itself is already presented). The cluster downshift register may be written at any idle time.
module detector_hit_histogram_engine #(
  parameter int STRIP_BINS     = dhh_pkg::STRIP_BINS_DEF,
  parameter int AMPLITUDE_BINS = dhh_pkg::AMPLITUDE_BINS_DEF,
  parameter int COUNT_WIDTH    = dhh_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [dhh_pkg::SHIFT_WIDTH-1:0] cfg_data,
  dhh_in_if.sink                          items,
  dhh_out_if.source                       results
);
  import dhh_pkg::*;

  localparam int SW       = $clog2(STRIP_BINS);
  localparam int AW       = $clog2(AMPLITUDE_BINS);
  localparam int MAX_BINS = (STRIP_BINS > AMPLITUDE_BINS) ? STRIP_BINS : AMPLITUDE_BINS;
  localparam int PW       = $clog2(MAX_BINS);
  localparam logic [PW-1:0] SWEEP_LAST = PW'(MAX_BINS - 1);

  localparam logic [1:0] S_SWEEP = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0]             state;
  logic [PW-1:0]          sweep_addr;
  logic [SHIFT_WIDTH-1:0] shift;
  logic [COUNT_WIDTH-1:0] hits_seen;
  logic [COUNT_WIDTH-1:0] clusters_seen;

  logic [1:0]    op_q;
  logic [2:0]    sel_q;
  logic          upd_q;
  logic          err_q;
  logic [SW-1:0] xs_q;
  logic [SW-1:0] ys_q;
  logic [AW-1:0] xa_q;
  logic [AW-1:0] ya_q;
  logic [AW-1:0] cl_q;

  logic [31:0]   cluster_shifted;
  logic          hit_ok;
  logic          clu_ok;
  logic          read_ok;
  logic          upd_next;
  logic          err_next;
  logic [SW-1:0] xs_next;
  logic [SW-1:0] ys_next;
  logic [AW-1:0] xa_next;
  logic [AW-1:0] ya_next;
  logic [AW-1:0] cl_next;

  logic [COUNT_WIDTH-1:0] x_strip_mem [STRIP_BINS];
  logic [COUNT_WIDTH-1:0] y_strip_mem [STRIP_BINS];
  logic [COUNT_WIDTH-1:0] x_amplitude_mem [AMPLITUDE_BINS];
  logic [COUNT_WIDTH-1:0] y_amplitude_mem [AMPLITUDE_BINS];
  logic [COUNT_WIDTH-1:0] cluster_mem [AMPLITUDE_BINS];
  logic [COUNT_WIDTH-1:0] xs_rd;
  logic [COUNT_WIDTH-1:0] ys_rd;
  logic [COUNT_WIDTH-1:0] xa_rd;
  logic [COUNT_WIDTH-1:0] ya_rd;
  logic [COUNT_WIDTH-1:0] cl_rd;

  logic          sweeping;
  logic          advance;
  logic          hit_we;
  logic          clu_we;
  logic [SW-1:0] xs_ra;
  logic [SW-1:0] ys_ra;
  logic [AW-1:0] xa_ra;
  logic [AW-1:0] ya_ra;
  logic [AW-1:0] cl_ra;
  logic [SW-1:0] xs_wa;
  logic [SW-1:0] ys_wa;
  logic [AW-1:0] xa_wa;
  logic [AW-1:0] ya_wa;
  logic [AW-1:0] cl_wa;

  logic [COUNT_WIDTH-1:0] hits_next;
  logic [COUNT_WIDTH-1:0] clusters_next;
  logic [COUNT_WIDTH-1:0] count_sel;
  logic [COUNT_WIDTH-1:0] bin_count_next;
  result_t                result_next;

  // decode and range-check the incoming word
  always_comb begin
    cluster_shifted = shift[SHIFT_WIDTH-1] ? 32'd0 :
                      (items.word.cluster_sum >> shift[SHIFT_WIDTH-2:0]);
    hit_ok = (32'(items.word.x_strip) < 32'(STRIP_BINS)) &&
             (32'(items.word.y_strip) < 32'(STRIP_BINS)) &&
             (32'(items.word.x_amplitude) < 32'(AMPLITUDE_BINS)) &&
             (32'(items.word.y_amplitude) < 32'(AMPLITUDE_BINS));
    clu_ok = cluster_shifted < 32'(AMPLITUDE_BINS);
    if (items.word.read_histogram == SEL_X_STRIP ||
        items.word.read_histogram == SEL_Y_STRIP) begin
      read_ok = 32'(items.word.read_bin) < 32'(STRIP_BINS);
    end else if (items.word.read_histogram == SEL_X_AMPLITUDE ||
                 items.word.read_histogram == SEL_Y_AMPLITUDE ||
                 items.word.read_histogram == SEL_CLUSTER_AMPLITUDE) begin
      read_ok = 32'(items.word.read_bin) < 32'(AMPLITUDE_BINS);
    end else begin
      read_ok = 1'b0;
    end
    case (items.word.op)
      OP_HIT: begin
        upd_next = hit_ok;
        err_next = !hit_ok;
      end
      OP_CLUSTER: begin
        upd_next = (items.word.cluster_sum != 32'd0) && clu_ok;
        err_next = (items.word.cluster_sum != 32'd0) && !clu_ok;
      end
      OP_READ: begin
        upd_next = 1'b0;
        err_next = !read_ok;
      end
      default: begin
        upd_next = 1'b0;
        err_next = 1'b0;
      end
    endcase
    if (items.word.op == OP_READ) begin
      xs_next = SW'(items.word.read_bin);
      ys_next = SW'(items.word.read_bin);
      xa_next = AW'(items.word.read_bin);
      ya_next = AW'(items.word.read_bin);
      cl_next = AW'(items.word.read_bin);
    end else begin
      xs_next = SW'(items.word.x_strip);
      ys_next = SW'(items.word.y_strip);
      xa_next = AW'(items.word.x_amplitude);
      ya_next = AW'(items.word.y_amplitude);
      cl_next = AW'(cluster_shifted);
    end
  end

  assign items.ready = (state == S_IDLE);
  assign sweeping    = (state == S_SWEEP);
  assign advance     = (state == S_EXEC) && (!results.valid || results.ready);
  assign hit_we      = advance && (op_q == OP_HIT) && upd_q;
  assign clu_we      = advance && (op_q == OP_CLUSTER) && upd_q;

  assign xs_ra = (state == S_IDLE) ? xs_next : xs_q;
  assign ys_ra = (state == S_IDLE) ? ys_next : ys_q;
  assign xa_ra = (state == S_IDLE) ? xa_next : xa_q;
  assign ya_ra = (state == S_IDLE) ? ya_next : ya_q;
  assign cl_ra = (state == S_IDLE) ? cl_next : cl_q;

  assign xs_wa = sweeping ? SW'(sweep_addr) : xs_q;
  assign ys_wa = sweeping ? SW'(sweep_addr) : ys_q;
  assign xa_wa = sweeping ? AW'(sweep_addr) : xa_q;
  assign ya_wa = sweeping ? AW'(sweep_addr) : ya_q;
  assign cl_wa = sweeping ? AW'(sweep_addr) : cl_q;

  always_ff @(posedge clk) begin
    if (sweeping || hit_we) begin
      x_strip_mem[xs_wa] <= sweeping ? '0 : xs_rd + COUNT_WIDTH'(1);
    end
    xs_rd <= x_strip_mem[xs_ra];
  end

  always_ff @(posedge clk) begin
    if (sweeping || hit_we) begin
      y_strip_mem[ys_wa] <= sweeping ? '0 : ys_rd + COUNT_WIDTH'(1);
    end
    ys_rd <= y_strip_mem[ys_ra];
  end

  always_ff @(posedge clk) begin
    if (sweeping || hit_we) begin
      x_amplitude_mem[xa_wa] <= sweeping ? '0 : xa_rd + COUNT_WIDTH'(1);
    end
    xa_rd <= x_amplitude_mem[xa_ra];
  end

  always_ff @(posedge clk) begin
    if (sweeping || hit_we) begin
      y_amplitude_mem[ya_wa] <= sweeping ? '0 : ya_rd + COUNT_WIDTH'(1);
    end
    ya_rd <= y_amplitude_mem[ya_ra];
  end

  always_ff @(posedge clk) begin
    if (sweeping || clu_we) begin
      cluster_mem[cl_wa] <= sweeping ? '0 : cl_rd + COUNT_WIDTH'(1);
    end
    cl_rd <= cluster_mem[cl_ra];
  end

  // build the result of the word held in the execute stage
  always_comb begin
    case (op_q)
      OP_HIT: begin
        hits_next     = upd_q ? hits_seen + COUNT_WIDTH'(1) : hits_seen;
        clusters_next = clusters_seen;
      end
      OP_CLUSTER: begin
        hits_next     = hits_seen;
        clusters_next = upd_q ? clusters_seen + COUNT_WIDTH'(1) : clusters_seen;
      end
      OP_CLEAR: begin
        hits_next     = '0;
        clusters_next = '0;
      end
      default: begin
        hits_next     = hits_seen;
        clusters_next = clusters_seen;
      end
    endcase
    case (sel_q)
      SEL_X_STRIP:     count_sel = xs_rd;
      SEL_Y_STRIP:     count_sel = ys_rd;
      SEL_X_AMPLITUDE: count_sel = xa_rd;
      SEL_Y_AMPLITUDE: count_sel = ya_rd;
      default:         count_sel = cl_rd;
    endcase
    bin_count_next = ((op_q == OP_READ) && !err_q) ? count_sel : '0;
    result_next.bin_count     = 32'(bin_count_next);
    result_next.hit_total     = 32'(hits_next);
    result_next.cluster_total = 32'(clusters_next);
    result_next.is_empty      = (hits_next == '0) && (clusters_next == '0);
    result_next.range_error   = err_q;
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      op_q  <= items.word.op;
      sel_q <= items.word.read_histogram;
      upd_q <= upd_next;
      err_q <= err_next;
      xs_q  <= xs_next;
      ys_q  <= ys_next;
      xa_q  <= xa_next;
      ya_q  <= ya_next;
      cl_q  <= cl_next;
    end
    if (advance) begin
      results.word <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_SWEEP;
      sweep_addr    <= '0;
      shift         <= '0;
      hits_seen     <= '0;
      clusters_seen <= '0;
      results.valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        shift <= cfg_data;
      end
      if (advance) begin
        results.valid <= 1'b1;
        hits_seen     <= hits_next;
        clusters_seen <= clusters_next;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
      case (state)
        S_SWEEP: begin
          if (sweep_addr == SWEEP_LAST) begin
            sweep_addr <= '0;
            state      <= S_IDLE;
          end else begin
            sweep_addr <= sweep_addr + PW'(1);
          end
        end
        S_IDLE: begin
          if (items.valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (advance) begin
            state <= (op_q == OP_CLEAR) ? S_SWEEP : S_IDLE;
          end
        end
        default: begin
          state <= S_SWEEP;
        end
      endcase
    end
  end

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    advance && (op_q == OP_CLEAR) |=> results.valid && results.word.is_empty &&
      (results.word.hit_total == 32'd0) && (results.word.cluster_total == 32'd0))
    else $error("clear word did not report empty totals");

  a_error_no_count: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.word.range_error |-> results.word.bin_count == 32'd0)
    else $error("range error reported with a nonzero bin count");

  a_hit_total_step: assert property (@(posedge clk) disable iff (rst)
    !$stable(hits_seen) |-> (hits_seen == '0) ||
      (hits_seen == $past(hits_seen) + COUNT_WIDTH'(1)))
    else $error("hit total moved by other than one");

  a_no_write_while_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !hit_we && !clu_we)
    else $error("histogram write outside the execute stage");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import dhh_pkg::*;

  localparam int SWEEP_WAIT = STRIP_BINS_DEF + 32;
  localparam int RANDOM_PER_PHASE = 275;
  localparam logic [2:0] SEL_NONE_LO  = 3'd5;
  localparam logic [2:0] SEL_NONE_MID = 3'd6;
  localparam logic [2:0] SEL_NONE_HI  = 3'd7;

  typedef struct {
    item_t   word;
    int      new_shift;
    bit      typed;
    result_t want;
  } row_t;

  logic       clk;
  logic       rst;
  logic       cfg_write;
  logic [5:0] cfg_data;

  dhh_in_if  in_words ();
  dhh_out_if out_words ();

  detector_hit_histogram_engine u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .items     (in_words),
    .results   (out_words)
  );

  logic [31:0] x_strip_cnt [STRIP_BINS_DEF];
  logic [31:0] y_strip_cnt [STRIP_BINS_DEF];
  logic [31:0] x_amp_cnt [AMPLITUDE_BINS_DEF];
  logic [31:0] y_amp_cnt [AMPLITUDE_BINS_DEF];
  logic [31:0] cluster_amp_cnt [AMPLITUDE_BINS_DEF];
  logic [31:0] hit_cnt;
  logic [31:0] cluster_cnt;
  int          shift_now;

  result_t due_results [$];
  row_t    script [$];
  int      errors;
  int      results_taken;
  bit      src_calm;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic void clear_counts();
    for (int i = 0; i < STRIP_BINS_DEF; i++) begin
      x_strip_cnt[i] = '0;
      y_strip_cnt[i] = '0;
    end
    for (int i = 0; i < AMPLITUDE_BINS_DEF; i++) begin
      x_amp_cnt[i] = '0;
      y_amp_cnt[i] = '0;
      cluster_amp_cnt[i] = '0;
    end
    hit_cnt = '0;
    cluster_cnt = '0;
  endfunction

  function automatic result_t histogram_step(item_t w);
    result_t     r;
    logic [31:0] bin;
    r = '0;
    case (w.op)
      OP_HIT: begin
        if (w.x_strip < STRIP_BINS_DEF && w.y_strip < STRIP_BINS_DEF &&
            w.x_amplitude < AMPLITUDE_BINS_DEF && w.y_amplitude < AMPLITUDE_BINS_DEF) begin
          x_strip_cnt[w.x_strip] = x_strip_cnt[w.x_strip] + 1;
          y_strip_cnt[w.y_strip] = y_strip_cnt[w.y_strip] + 1;
          x_amp_cnt[w.x_amplitude] = x_amp_cnt[w.x_amplitude] + 1;
          y_amp_cnt[w.y_amplitude] = y_amp_cnt[w.y_amplitude] + 1;
          hit_cnt = hit_cnt + 1;
        end else begin
          r.range_error = 1'b1;
        end
      end
      OP_CLUSTER: begin
        if (w.cluster_sum != '0) begin
          bin = (shift_now >= 32) ? '0 : (w.cluster_sum >> shift_now);
          if (bin < AMPLITUDE_BINS_DEF) begin
            cluster_amp_cnt[bin] = cluster_amp_cnt[bin] + 1;
            cluster_cnt = cluster_cnt + 1;
          end else begin
            r.range_error = 1'b1;
          end
        end
      end
      OP_CLEAR: clear_counts();
      default: begin
        if (w.read_bin >= STRIP_BINS_DEF && w.read_histogram <= SEL_Y_STRIP) begin
          r.range_error = 1'b1;
        end else if (w.read_bin >= AMPLITUDE_BINS_DEF && w.read_histogram > SEL_Y_STRIP) begin
          r.range_error = 1'b1;
        end else begin
          case (w.read_histogram)
            SEL_X_STRIP:           r.bin_count = x_strip_cnt[w.read_bin];
            SEL_Y_STRIP:           r.bin_count = y_strip_cnt[w.read_bin];
            SEL_X_AMPLITUDE:       r.bin_count = x_amp_cnt[w.read_bin];
            SEL_Y_AMPLITUDE:       r.bin_count = y_amp_cnt[w.read_bin];
            SEL_CLUSTER_AMPLITUDE: r.bin_count = cluster_amp_cnt[w.read_bin];
            default:               r.range_error = 1'b1;
          endcase
        end
      end
    endcase
    r.hit_total = hit_cnt;
    r.cluster_total = cluster_cnt;
    r.is_empty = (hit_cnt == '0) && (cluster_cnt == '0);
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s got %0h want %0h", $time, field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst && out_words.valid === 1'b1 && out_words.ready === 1'b1) begin
      got = out_words.word;
      results_taken++;
      if (due_results.size() == 0) begin
        report_mismatch("unexpected word, bin_count", got.bin_count, '0);
      end else begin
        want = due_results.pop_front();
        if (got.bin_count !== want.bin_count)
          report_mismatch("bin_count", got.bin_count, want.bin_count);
        if (got.hit_total !== want.hit_total)
          report_mismatch("hit_total", got.hit_total, want.hit_total);
        if (got.cluster_total !== want.cluster_total)
          report_mismatch("cluster_total", got.cluster_total, want.cluster_total);
        if (got.is_empty !== want.is_empty)
          report_mismatch("is_empty", {31'd0, got.is_empty}, {31'd0, want.is_empty});
        if (got.range_error !== want.range_error)
          report_mismatch("range_error", {31'd0, got.range_error}, {31'd0, want.range_error});
      end
    end
  end

  initial begin
    int  hold_left;
    int  ticks;
    bit  held_off;
    bit  sink_calm;
    hold_left = 0;
    ticks = 0;
    held_off = 1'b0;
    sink_calm = 1'b0;
    out_words.ready = 1'b0;
    forever begin
      @(negedge clk);
      ticks++;
      if (ticks % 64 == 0) begin
        sink_calm = ($urandom_range(0, 3) == 0);
      end
      // hold off long enough to back the block up to its input
      if (!held_off && results_taken >= 400) begin
        held_off = 1'b1;
        hold_left = 300;
      end else if (hold_left == 0 && !sink_calm && $urandom_range(0, 3) == 0) begin
        hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
      out_words.ready <= (hold_left == 0);
      if (hold_left > 0) begin
        hold_left--;
      end
    end
  end

  function automatic int pick_gap();
    if (src_calm) begin
      return 0;
    end
    case ($urandom_range(0, 19))
      0:          return $urandom_range(10, 40);
      1, 2, 3, 4: return $urandom_range(1, 3);
      default:    return 0;
    endcase
  endfunction

  task automatic send_word(item_t w, bit typed, result_t want);
    int      gap;
    result_t calc;
    gap = pick_gap();
    if (gap > 0) begin
      in_words.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_words.valid <= 1'b1;
    in_words.word <= w;
    @(posedge clk);
    while (in_words.ready !== 1'b1) @(posedge clk);
    calc = histogram_step(w);
    due_results.push_back(typed ? want : calc);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_words.valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (SWEEP_WAIT) @(negedge clk);
  endtask

  task automatic write_shift(logic [5:0] s);
    cfg_write <= 1'b1;
    cfg_data <= s;
    @(negedge clk);
    cfg_write <= 1'b0;
    shift_now = (s > 6'd32) ? 32 : int'(s);
  endtask

  function automatic item_t hit_word(logic [9:0] xs, logic [9:0] xa, logic [9:0] ys,
                                     logic [9:0] ya);
    item_t w;
    w = '0;
    w.op = OP_HIT;
    w.x_strip = xs;
    w.x_amplitude = xa;
    w.y_strip = ys;
    w.y_amplitude = ya;
    return w;
  endfunction

  function automatic item_t cluster_word(logic [31:0] sum);
    item_t w;
    w = '0;
    w.op = OP_CLUSTER;
    w.cluster_sum = sum;
    return w;
  endfunction

  function automatic item_t read_word(logic [2:0] sel, logic [9:0] bin);
    item_t w;
    w = '0;
    w.op = OP_READ;
    w.read_histogram = sel;
    w.read_bin = bin;
    return w;
  endfunction

  function automatic result_t outcome(logic [31:0] cnt, logic [31:0] hits,
                                      logic [31:0] clusters, logic empty, logic err);
    result_t r;
    r.bin_count = cnt;
    r.hit_total = hits;
    r.cluster_total = clusters;
    r.is_empty = empty;
    r.range_error = err;
    return r;
  endfunction

  task automatic put(item_t w, int new_shift, bit typed, result_t want);
    row_t r;
    r.word = w;
    r.new_shift = new_shift;
    r.typed = typed;
    r.want = want;
    script.push_back(r);
  endtask

  function automatic logic [9:0] pick_index();
    logic [31:0] r;
    int          k;
    r = $urandom;
    k = $urandom_range(0, 9);
    if (k < 4) begin
      return {7'd0, r[2:0]};
    end
    if (k == 4) begin
      return {7'h7f, r[2:0]};
    end
    return r[9:0];
  endfunction

  function automatic item_t random_word();
    item_t       w;
    logic [31:0] r;
    int          k;
    r = $urandom;
    w.x_strip = r[9:0];
    w.x_amplitude = r[19:10];
    w.y_strip = r[29:20];
    r = $urandom;
    w.y_amplitude = r[9:0];
    w.read_histogram = r[12:10];
    w.read_bin = r[22:13];
    w.cluster_sum = $urandom;
    k = $urandom_range(0, 99);
    if (k < 45) begin
      w.op = OP_HIT;
      w.x_strip = pick_index();
      w.x_amplitude = pick_index();
      w.y_strip = pick_index();
      w.y_amplitude = pick_index();
    end else if (k < 70) begin
      w.op = OP_CLUSTER;
      r = $urandom;
      w.cluster_sum = r >> $urandom_range(0, 31);
      if ($urandom_range(0, 15) == 0) begin
        w.cluster_sum = '0;
      end else if (w.cluster_sum == '0) begin
        w.cluster_sum = 32'd1;
      end
    end else if (k < 99) begin
      w.op = OP_READ;
      r = ($urandom_range(0, 9) == 0) ? $urandom_range(SEL_NONE_LO, SEL_NONE_HI)
                                      : $urandom_range(SEL_X_STRIP, SEL_CLUSTER_AMPLITUDE);
      w.read_histogram = r[2:0];
      w.read_bin = pick_index();
    end else begin
      w.op = OP_CLEAR;
    end
    return w;
  endfunction

  initial begin
    logic [5:0] phase_shift [6];
    logic [31:0] r;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = '0;
    in_words.valid = 1'b0;
    in_words.word = '0;
    errors = 0;
    results_taken = 0;
    src_calm = 1'b0;
    shift_now = 0;
    clear_counts();

    put(read_word(SEL_X_STRIP, 10'd0), -1, 1, outcome(0, 0, 0, 1, 0));
    put(read_word(SEL_NONE_LO, 10'd0), -1, 1, outcome(0, 0, 0, 1, 1));
    put(read_word(SEL_NONE_HI, 10'd1023), -1, 1, outcome(0, 0, 0, 1, 1));
    put(cluster_word(32'd0), -1, 1, outcome(0, 0, 0, 1, 0));
    put(hit_word(10'd0, 10'd0, 10'd0, 10'd0), -1, 1, outcome(0, 1, 0, 0, 0));
    put(hit_word(10'd1023, 10'd1023, 10'd1023, 10'd1023), -1, 1, outcome(0, 2, 0, 0, 0));
    put(cluster_word(32'd1), -1, 1, outcome(0, 2, 1, 0, 0));
    put(cluster_word(32'd1023), -1, 1, outcome(0, 2, 2, 0, 0));
    put(cluster_word(32'd1024), -1, 1, outcome(0, 2, 2, 0, 1));
    put(cluster_word(32'hffff_ffff), -1, 1, outcome(0, 2, 2, 0, 1));
    put(read_word(SEL_X_STRIP, 10'd0), -1, 1, outcome(1, 2, 2, 0, 0));
    put(read_word(SEL_Y_STRIP, 10'd1023), -1, 1, outcome(1, 2, 2, 0, 0));
    put(read_word(SEL_X_AMPLITUDE, 10'd1023), -1, 1, outcome(1, 2, 2, 0, 0));
    put(read_word(SEL_Y_AMPLITUDE, 10'd0), -1, 1, outcome(1, 2, 2, 0, 0));
    put(read_word(SEL_CLUSTER_AMPLITUDE, 10'd1023), -1, 1, outcome(1, 2, 2, 0, 0));
    put(read_word(SEL_CLUSTER_AMPLITUDE, 10'd1), -1, 1, outcome(1, 2, 2, 0, 0));
    put(cluster_word(32'hffff_ffff), 63, 1, outcome(0, 2, 3, 0, 0));
    put(read_word(SEL_CLUSTER_AMPLITUDE, 10'd0), -1, 1, outcome(1, 2, 3, 0, 0));
    put(cluster_word(32'h8000_0000), 32, 1, outcome(0, 2, 4, 0, 0));
    put(cluster_word(32'hffff_ffff), 22, 1, outcome(0, 2, 5, 0, 0));
    put(cluster_word(32'hffff_ffff), 21, 1, outcome(0, 2, 5, 0, 1));
    put('{op: OP_CLEAR, default: '0}, -1, 1, outcome(0, 0, 0, 1, 0));
    put(read_word(SEL_CLUSTER_AMPLITUDE, 10'd1023), -1, 1, outcome(0, 0, 0, 1, 0));
    put(read_word(SEL_NONE_MID, 10'd0), -1, 1, outcome(0, 0, 0, 1, 1));
    put(hit_word(10'h155, 10'h2aa, 10'h2aa, 10'h155), -1, 0, '0);
    put(read_word(SEL_X_STRIP, 10'h155), -1, 0, '0);

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].new_shift >= 0) begin
        wait_idle();
        write_shift(script[i].new_shift[5:0]);
      end
      send_word(script[i].word, script[i].typed, script[i].want);
    end

    r = $urandom_range(0, 63);
    phase_shift = '{6'd0, 6'd63, 6'd10, 6'd32, 6'd3, r[5:0]};
    foreach (phase_shift[p]) begin
      wait_idle();
      write_shift(phase_shift[p]);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n % 64 == 0) begin
          src_calm = ($urandom_range(0, 3) == 0);
        end
        send_word(random_word(), 1'b0, '0);
      end
    end

    in_words.valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/dhh_pkg.sv
rtl/dhh_in_if.sv
rtl/dhh_out_if.sv
rtl/detector_hit_histogram_engine.sv
tb/tb_top.sv
